// ===== sv/tlp_pkg.sv =====
`default_nettype none

package tlp_pkg;

   localparam int HEX_DIGITS_DEFAULT = 8;
   localparam int REG_DIGITS = 3;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_STAR  = 8'h2a;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_LT    = 8'h3c;
   localparam logic [7:0] CHAR_EQ    = 8'h3d;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_line;
   } tlp_char_type;

   typedef struct packed {
      logic        format_ok;
      logic [31:0] time_value;
      logic [31:0] pc_value;
      logic        to_memory;
      logic [31:0] target_address;
      logic [31:0] write_data;
   } tlp_result_type;

   function automatic logic is_dec(input logic [7:0] c);
      return c inside {[CHAR_0:CHAR_9]};
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return (c inside {[CHAR_0:CHAR_9]}) || (c inside {[CHAR_A:CHAR_F]});
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (is_dec(c)) begin
         v = c - CHAR_0;
      end else begin
         v = c - CHAR_A + HEX_LETTER_BASE;
      end
      return v[3:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/tlp_if.sv =====
`default_nettype none

interface tlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_line;

   modport source (output valid, output char_in, output end_of_line, input ready);
   modport sink (input valid, input char_in, input end_of_line, output ready);
endinterface

interface tlp_rsp_if;
   logic        valid;
   logic        ready;
   logic        format_ok;
   logic [31:0] time_value;
   logic [31:0] pc_value;
   logic        to_memory;
   logic [31:0] target_address;
   logic [31:0] write_data;

   modport source (output valid, output format_ok, output time_value, output pc_value,
                   output to_memory, output target_address, output write_data,
                   input ready);
   modport sink (input valid, input format_ok, input time_value, input pc_value,
                 input to_memory, input target_address, input write_data,
                 output ready);
endinterface

`default_nettype wire

// ===== sv/tlp_parse_core.sv =====
`default_nettype none

module tlp_parse_core #(
   parameter int HEX_DIGITS = tlp_pkg::HEX_DIGITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire tlp_pkg::tlp_char_type  char_req,
   output tlp_pkg::tlp_result_type     result
);

   localparam int MAX_COUNT = (HEX_DIGITS > tlp_pkg::REG_DIGITS) ? HEX_DIGITS
                                                                  : tlp_pkg::REG_DIGITS;
   localparam int CW = $clog2(MAX_COUNT + 1);
   localparam logic [CW-1:0] HEX_COUNT = CW'(HEX_DIGITS);
   localparam logic [CW-1:0] REG_COUNT = CW'(tlp_pkg::REG_DIGITS);
   localparam logic [CW-1:0] ONE = CW'(1);

   typedef enum logic [3:0] {
      PH_SEEK_TIME, PH_TIME, PH_SEEK_AT, PH_SEEK_PC, PH_PC, PH_SEEK_COLON,
      PH_SEEK_DEST, PH_SEEK_ADDR, PH_REG, PH_MEM, PH_SEEK_LT, PH_EXPECT_EQ,
      PH_SEEK_DATA, PH_DATA, PH_DONE, PH_FAIL
   } phase_type;

   phase_type      phase_ff, phase_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [31:0]    time_ff, time_in;
   logic [31:0]    pc_ff, pc_in;
   logic           dest_ff, dest_in;
   logic [31:0]    addr_ff, addr_in;
   logic [31:0]    data_ff, data_in;
   logic           ended_ff, ended_in;

   logic [7:0]  c;
   logic        c_dec;
   logic        c_hex;
   logic [3:0]  hv;
   logic [31:0] dec_ext;
   logic        ok;
   phase_type   lt_phase;

   assign c       = char_req.char_in;
   assign c_dec   = tlp_pkg::is_dec(c);
   assign c_hex   = tlp_pkg::is_hex(c);
   assign hv      = tlp_pkg::hex_val(c);
   assign dec_ext = {28'd0, hv};
   assign lt_phase = (c == tlp_pkg::CHAR_LT) ? PH_EXPECT_EQ : PH_SEEK_LT;

   assign ok = (phase_ff == PH_DONE) || (phase_ff == PH_DATA && count_ff == HEX_COUNT);

   always_comb begin
      result.format_ok      = ok;
      result.time_value     = ok ? time_ff : 32'd0;
      result.pc_value       = ok ? pc_ff : 32'd0;
      result.to_memory      = ok & dest_ff;
      result.target_address = ok ? addr_ff : 32'd0;
      result.write_data     = ok ? data_ff : 32'd0;
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      time_in  = time_ff;
      pc_in    = pc_ff;
      dest_in  = dest_ff;
      addr_in  = addr_ff;
      data_in  = data_ff;
      ended_in = ended_ff;
      if (step && char_req.end_of_line) begin
         phase_in = PH_SEEK_TIME;
         count_in = '0;
         time_in  = '0;
         pc_in    = '0;
         dest_in  = 1'b0;
         addr_in  = '0;
         data_in  = '0;
         ended_in = 1'b0;
      end else if (step && !ended_ff) begin
         if (c == tlp_pkg::CHAR_NUL) begin
            ended_in = 1'b1;
         end else begin
            case (phase_ff)
               PH_SEEK_TIME: begin
                  if (c == tlp_pkg::CHAR_AT) begin
                     phase_in = PH_SEEK_PC;
                  end else if (c_dec) begin
                     time_in  = dec_ext;
                     phase_in = PH_TIME;
                  end
               end
               PH_TIME: begin
                  if (c_dec) begin
                     // times ten as two shifts
                     time_in = {time_ff[28:0], 3'b000} + {time_ff[30:0], 1'b0} + dec_ext;
                  end else begin
                     phase_in = (c == tlp_pkg::CHAR_AT) ? PH_SEEK_PC : PH_SEEK_AT;
                  end
               end
               PH_SEEK_AT: begin
                  if (c == tlp_pkg::CHAR_AT) phase_in = PH_SEEK_PC;
               end
               PH_SEEK_PC: begin
                  if (c_hex) begin
                     pc_in    = dec_ext;
                     count_in = ONE;
                     phase_in = PH_PC;
                  end
               end
               PH_PC: begin
                  if (c_hex) begin
                     if (count_ff >= HEX_COUNT) begin
                        phase_in = PH_FAIL;
                     end else begin
                        pc_in    = {pc_ff[27:0], hv};
                        count_in = count_ff + ONE;
                     end
                  end else if (count_ff != HEX_COUNT) begin
                     phase_in = PH_FAIL;
                  end else begin
                     phase_in = (c == tlp_pkg::CHAR_COLON) ? PH_SEEK_DEST : PH_SEEK_COLON;
                  end
               end
               PH_SEEK_COLON: begin
                  if (c == tlp_pkg::CHAR_COLON) phase_in = PH_SEEK_DEST;
               end
               PH_SEEK_DEST: begin
                  if (c == tlp_pkg::CHAR_DOLLAR) begin
                     dest_in  = 1'b0;
                     phase_in = PH_SEEK_ADDR;
                  end else if (c == tlp_pkg::CHAR_STAR) begin
                     dest_in  = 1'b1;
                     phase_in = PH_SEEK_ADDR;
                  end
               end
               PH_SEEK_ADDR: begin
                  if (c_hex) begin
                     if (dest_ff) begin
                        addr_in  = dec_ext;
                        count_in = ONE;
                        phase_in = PH_MEM;
                     end else if (c_dec) begin
                        addr_in  = dec_ext;
                        count_in = ONE;
                        phase_in = PH_REG;
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end
               end
               PH_REG: begin
                  if (c_dec) begin
                     if (count_ff >= REG_COUNT) begin
                        phase_in = PH_FAIL;
                     end else begin
                        addr_in  = {addr_ff[28:0], 3'b000} + {addr_ff[30:0], 1'b0} + dec_ext;
                        count_in = count_ff + ONE;
                     end
                  end else if (c_hex) begin
                     phase_in = PH_FAIL;
                  end else begin
                     phase_in = lt_phase;
                  end
               end
               PH_MEM: begin
                  if (c_hex) begin
                     if (count_ff >= HEX_COUNT) begin
                        phase_in = PH_FAIL;
                     end else begin
                        addr_in  = {addr_ff[27:0], hv};
                        count_in = count_ff + ONE;
                     end
                  end else if (count_ff != HEX_COUNT) begin
                     phase_in = PH_FAIL;
                  end else begin
                     phase_in = lt_phase;
                  end
               end
               PH_SEEK_LT: begin
                  phase_in = lt_phase;
               end
               PH_EXPECT_EQ: begin
                  phase_in = (c == tlp_pkg::CHAR_EQ) ? PH_SEEK_DATA : PH_FAIL;
               end
               PH_SEEK_DATA: begin
                  if (c_hex) begin
                     data_in  = dec_ext;
                     count_in = ONE;
                     phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  if (c_hex) begin
                     if (count_ff >= HEX_COUNT) begin
                        phase_in = PH_FAIL;
                     end else begin
                        data_in  = {data_ff[27:0], hv};
                        count_in = count_ff + ONE;
                     end
                  end else begin
                     phase_in = (count_ff == HEX_COUNT) ? PH_DONE : PH_FAIL;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK_TIME;
         count_ff <= '0;
         time_ff  <= '0;
         pc_ff    <= '0;
         dest_ff  <= 1'b0;
         addr_ff  <= '0;
         data_ff  <= '0;
         ended_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         time_ff  <= time_in;
         pc_ff    <= pc_in;
         dest_ff  <= dest_in;
         addr_ff  <= addr_in;
         data_ff  <= data_in;
         ended_ff <= ended_in;
      end
   end

   // after a zero byte nothing moves until the line closes
   a_ended_frozen: assert property (@(posedge clock) disable iff (reset)
      ended_ff && !(step && char_req.end_of_line) |=> $stable(phase_ff) && $stable(addr_ff))
      else $error("parser state moved after early end of line");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_COUNT))
      else $error("digit count beyond its limit");

   a_ok_has_dest: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |-> count_ff == HEX_COUNT)
      else $error("line done without a full data word");

endmodule

`default_nettype wire

// ===== sv/trace_line_parser.sv =====
`default_nettype none

// Parses one CPU write-trace line of the form  time@pc: $reg <= data  or
// time@pc: *addr <= data, one character per request.
// req_chan carries char_in and end_of_line. A request with end_of_line set
// ignores its byte, closes the line and yields exactly one response on
// rsp_chan; all other requests yield none. A zero byte ends the line early,
// later bytes are dropped until end_of_line.
// The response holds format_ok and the fields; a bad line reads all zero.
// A request is captured in an input register, then updated into the
// parser state; an end-of-line request lands in the response register at
// that same edge, and rsp_chan.valid is driven from the response register.
// Throughput: one request per cycle, except that a stalled response holds
// back an end-of-line request; characters keep flowing while the response
// waits.
// Reset clears the parser state and empties both registers.
module trace_line_parser #(
   parameter int HEX_DIGITS = tlp_pkg::HEX_DIGITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   tlp_req_if.sink   req_chan,
   tlp_rsp_if.source rsp_chan
);

   logic                    in_valid_ff;
   tlp_pkg::tlp_char_type   in_data_ff;
   logic                    rsp_valid_ff;
   tlp_pkg::tlp_result_type rsp_data_ff;
   tlp_pkg::tlp_result_type core_result;
   logic                    advance;
   logic                    close_line;

   assign advance = in_valid_ff &&
                    (!in_data_ff.end_of_line || !rsp_valid_ff || rsp_chan.ready);
   assign close_line = advance && in_data_ff.end_of_line;
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_data_ff.char_in     <= req_chan.char_in;
         in_data_ff.end_of_line <= req_chan.end_of_line;
      end
   end

   tlp_parse_core #(
      .HEX_DIGITS(HEX_DIGITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .char_req (in_data_ff),
      .result   (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (close_line) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (close_line) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.format_ok      = rsp_data_ff.format_ok;
   assign rsp_chan.time_value     = rsp_data_ff.time_value;
   assign rsp_chan.pc_value       = rsp_data_ff.pc_value;
   assign rsp_chan.to_memory      = rsp_data_ff.to_memory;
   assign rsp_chan.target_address = rsp_data_ff.target_address;
   assign rsp_chan.write_data     = rsp_data_ff.write_data;

   a_bad_line_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.format_ok |->
         rsp_data_ff.time_value == 32'd0 && rsp_data_ff.pc_value == 32'd0 &&
         !rsp_data_ff.to_memory && rsp_data_ff.target_address == 32'd0 &&
         rsp_data_ff.write_data == 32'd0)
      else $error("failed line carries nonzero fields");

   a_rsp_from_eol: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_data_ff.end_of_line))
      else $error("response without an end-of-line request");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !close_line)
      else $error("pending response overwritten");

endmodule

`default_nettype wire
